>>> rtl/core/vfjq_pkg.sv
package vfjq_pkg;

	// Ring geometry
	localparam int SLOTS       = 16;
	localparam int FRAME_BYTES = 40;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int SUM_W       = SLOT_W + 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
	localparam int MEM_DEPTH   = SLOTS * FRAME_BYTES;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	// Threshold register
	localparam int FILL_W = 4;
	localparam logic [FILL_W-1:0] MIN_FILL_RST = FILL_W'(3);

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	// One input word as it travels from the front queue to the back end
	typedef struct packed {
		action_t    action;
		logic [7:0] byte_value;
		logic       last_byte;
	} cmd_t;

	// One result word held in the output queue
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_none;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_STREAM
	} back_state_t;

	// First byte address of a slot
	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
		return ADDR_W'(int'(slot) * FRAME_BYTES);
	endfunction

endpackage

>>> rtl/core/vfjq_ram.sv
module vfjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/vfjq_front.sv
module vfjq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           action,
	input  logic [7:0]     byte_value,
	input  logic           last_byte,
	output vfjq_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);
	import vfjq_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Classify and hold incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{action: action_t'(action), byte_value: byte_value,
				last_byte: last_byte};
		end
	end

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/vfjq_back.sv
module vfjq_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vfjq_pkg::cmd_t                cmd,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic                          cfg_we,
	input  logic [vfjq_pkg::FILL_W-1:0]   cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          out_last,
	output logic                          out_none
);
	import vfjq_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [CNT_W-1:0]  held_q;
	logic [SLOT_W-1:0] head_q;
	logic [LEN_W-1:0]  wo_q;
	logic [FILL_W-1:0] min_fill_q;
	logic [LEN_W-1:0]  len_arr_q [SLOTS];
	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  len_q;
	logic              vld_s1;
	logic              last_s1;
	logic              none_s1;
	res_t              res_q [2];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;

	logic              credit;
	logic              is_pop;
	logic              flush;
	logic [CNT_W-1:0]  held_eff;
	logic [SLOT_W-1:0] head_eff;
	logic [SUM_W-1:0]  tail_sum;
	logic [SLOT_W-1:0] tail;
	logic              room;
	logic [LEN_W-1:0]  wo_inc;
	logic              avail;
	logic              k_last;
	logic              do_push;
	logic              do_start;
	logic              do_none;
	logic              do_read;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              opop;

	// Output queue space, counting a read still in flight
	assign credit = (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && !vld_s1);
	assign is_pop = (cmd.action == ACT_POP);

	// Push path: flush a full ring on a new frame, then find the tail slot
	assign flush    = (wo_q == '0) && (held_q >= CNT_W'(SLOTS));
	assign held_eff = flush ? '0 : held_q;
	assign head_eff = flush ? '0 : head_q;
	assign tail_sum = SUM_W'(head_eff) + SUM_W'(held_eff);
	assign tail     = (tail_sum >= SUM_W'(SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(SLOTS))
		: SLOT_W'(tail_sum);
	assign room     = (wo_q < LEN_W'(FRAME_BYTES));
	assign wo_inc   = room ? wo_q + LEN_W'(1) : wo_q;

	// Pop path: a frame is handed out only inside the fill window
	assign avail  = (held_q != '0) && (8'(held_q) >= 8'(min_fill_q))
		&& (held_q < CNT_W'(SLOTS));
	assign k_last = ((k_q + LEN_W'(1)) == len_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (do_start) begin
					state_d = BK_STREAM;
				end
			end
			BK_STREAM: begin
				if (do_read && k_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Command take and read issue
	always_comb begin
		cmd_ready = 1'b0;
		do_push   = 1'b0;
		do_start  = 1'b0;
		do_none   = 1'b0;
		do_read   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					priority if (!is_pop) begin
						cmd_ready = 1'b1;
						do_push   = 1'b1;
					end else if (avail) begin
						cmd_ready = 1'b1;
						do_start  = 1'b1;
					end else if (credit) begin
						cmd_ready = 1'b1;
						do_none   = 1'b1;
					end
				end
			end
			BK_STREAM: begin
				do_read = credit;
			end
			default: ;
		endcase
	end

	assign ram_we    = do_push && room;
	assign ram_waddr = slot_base(tail) + ADDR_W'(wo_q);
	assign ram_raddr = base_q + ADDR_W'(k_q);

	vfjq_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.byte_value),
		.re   (do_read),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			held_q     <= '0;
			head_q     <= '0;
			wo_q       <= '0;
			min_fill_q <= MIN_FILL_RST;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			none_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				min_fill_q <= cfg_wdata;
			end
			if (do_push) begin
				head_q <= head_eff;
				held_q <= cmd.last_byte ? held_eff + CNT_W'(1) : held_eff;
				wo_q   <= cmd.last_byte ? '0 : wo_inc;
			end else if (do_start) begin
				head_q <= (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
				held_q <= held_q - CNT_W'(1);
			end
			vld_s1  <= do_read || do_none;
			last_s1 <= do_none || (do_read && k_last);
			none_s1 <= do_none;
		end
	end

	// Frame lengths and stream position
	always_ff @(posedge clk) begin
		if (do_push && cmd.last_byte) begin
			len_arr_q[tail] <= wo_inc;
		end
		if (do_start) begin
			base_q <= slot_base(head_q);
			len_q  <= len_arr_q[head_q];
			k_q    <= '0;
		end else if (do_read) begin
			k_q <= k_q + LEN_W'(1);
		end
	end

	// Output queue
	assign opop      = out_valid && out_ready;
	assign out_valid = (ocnt_q != 2'd0);
	assign out_byte  = res_q[ord_q].out_byte;
	assign out_last  = res_q[ord_q].out_last;
	assign out_none  = res_q[ord_q].out_none;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_q[owr_q] <= none_s1 ? '{out_byte: 8'd0, out_last: 1'b1, out_none: 1'b1}
				: '{out_byte: ram_rdata, out_last: last_s1, out_none: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (vld_s1) begin
				owr_q <= ~owr_q;
			end
			if (opop) begin
				ord_q <= ~ord_q;
			end
			if (vld_s1 && !opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (opop && !vld_s1) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/voice_frame_jitter_queue.sv
// Jitter queue for voice frames: a ring of 16 slots of up to 40 bytes each.
// Input channel (in_valid/in_ready): one word per push byte (action 0, with
// last_byte on the closing byte) or per pop request (action 1). A frame only
// becomes visible once its closing byte is in; bytes past 40 are dropped.
// Output channel (out_valid/out_ready): a pop gives the oldest frame byte by
// byte with out_last on its final byte, or one word with out_none and
// out_last set when none or fewer than min_fill frames are held or the ring is full.
// min_fill is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce it. A two-word input
// queue feeds the executing back end, so input words are taken one per cycle
// while there is room. The idle back end takes a push word directly. A pop first
// latches the oldest slot's base and length, then issues a frame memory read
// only when the output queue has room for it beside the word in flight; each
// byte passes the memory read register before it enters the output queue.
// Reset clears the ring (no frames held, no partial frame) and sets min_fill
// to 3; the frame memory needs no clearing. When the receiver stalls, results
// wait in a two-word output queue, the back end pauses, and the input queue
// keeps taking words until it fills.
module voice_frame_jitter_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [7:0]                  byte_value,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        out_last,
	output logic                        out_none,
	input  logic                        cfg_we,
	input  logic [vfjq_pkg::FILL_W-1:0] cfg_wdata
);
	import vfjq_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	vfjq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.byte_value(byte_value),
		.last_byte (last_byte),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	vfjq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last),
		.out_none (out_none)
	);

endmodule

>>> verif/tb_top.sv
module tb_top;
	import vfjq_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_WAIT      = 18;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic                action     = 1'b0;
	logic [7:0]          byte_value = 8'h00;
	logic                last_byte  = 1'b0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [7:0]          out_byte;
	logic                out_last;
	logic                out_none;
	logic                cfg_we     = 1'b0;
	logic [FILL_W-1:0]   cfg_wdata  = MIN_FILL_RST;

	// Words waiting to be sent, and result words owed by the block
	cmd_t        pending_words[$];
	res_t        pop_words_due[$];
	int unsigned queued_items;

	// Handshake flags sampled at the rising edge, used at the next falling edge
	logic        in_taken  = 1'b0;
	logic        out_taken = 1'b0;
	int unsigned send_gap;
	int unsigned take_stall;
	bit          send_calm;
	bit          take_calm;
	int unsigned stall_draw;
	cmd_t        next_word;
	cmd_t        seen_word;
	res_t        due_word;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	// Shadow of the frame ring
	logic [7:0]        ring_mem [SLOTS][FRAME_BYTES];
	int unsigned       ring_len [SLOTS];
	int unsigned       ring_held;
	int unsigned       ring_head;
	int unsigned       ring_woff;
	logic [FILL_W-1:0] ring_min_fill;

	voice_frame_jitter_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.out_none   (out_none),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Apply one accepted word to the shadow ring and queue the words a pop owes
	task automatic advance_ring(input cmd_t c);
		res_t        r;
		int unsigned slot;
		int unsigned len;
		if (c.action == ACT_PUSH) begin
			// flush a full ring when a new frame starts
			if (ring_woff == 0 && ring_held >= SLOTS) begin
				ring_held = 0;
				ring_head = 0;
			end
			slot = (ring_head + ring_held) % SLOTS;
			// drop bytes past the slot size
			if (ring_woff < FRAME_BYTES) begin
				ring_mem[slot][ring_woff] = c.byte_value;
				ring_woff++;
			end
			if (c.last_byte) begin
				ring_len[slot] = ring_woff;
				ring_held++;
				ring_woff = 0;
			end
		end else if (ring_held > 0 && ring_held >= ring_min_fill && ring_held < SLOTS) begin
			slot = ring_head;
			len  = ring_len[slot];
			for (int k = 0; k < len; k++) begin
				r.out_byte = ring_mem[slot][k];
				r.out_last = (k + 1 == len);
				r.out_none = 1'b0;
				pop_words_due.push_back(r);
			end
			ring_head = (slot + 1) % SLOTS;
			ring_held--;
		end else begin
			r.out_byte = 8'h00;
			r.out_last = 1'b1;
			r.out_none = 1'b1;
			pop_words_due.push_back(r);
		end
	endtask

	// Sample both channels, predict on input words, check output words
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken  <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			cycle_count++;
			in_taken  <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			if (in_valid && in_ready) begin
				seen_word.action     = action_t'(action);
				seen_word.byte_value = byte_value;
				seen_word.last_byte  = last_byte;
				advance_ring(seen_word);
			end
			if (out_valid && out_ready) begin
				if (pop_words_due.size() == 0) begin
					$display("%0t: unexpected word byte=%02h last=%0b none=%0b",
						$time, out_byte, out_last, out_none);
					mismatch_count++;
				end else begin
					due_word = pop_words_due.pop_front();
					if (out_byte !== due_word.out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, due_word.out_byte, out_byte);
						mismatch_count++;
					end
					if (out_last !== due_word.out_last) begin
						$display("%0t: out_last expected %0b actual %0b",
							$time, due_word.out_last, out_last);
						mismatch_count++;
					end
					if (out_none !== due_word.out_none) begin
						$display("%0t: out_none expected %0b actual %0b",
							$time, due_word.out_none, out_none);
						mismatch_count++;
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("%0t: timeout, %0d words still owed", $time, pop_words_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Send pending words, with a random gap after each one
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0 || pending_words.size() == 0) begin
				in_valid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else begin
				next_word = pending_words.pop_front();
				in_valid   <= 1'b1;
				action     <= next_word.action;
				byte_value <= next_word.byte_value;
				last_byte  <= next_word.last_byte;
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap <= draw_wait(send_calm);
			end
		end
	end

	// Stall the result side for a random count after each word taken
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			take_stall <= 0;
		end else if (out_taken) begin
			if ($urandom_range(0, 39) == 0)
				take_calm = !take_calm;
			stall_draw = draw_wait(take_calm);
			take_stall <= stall_draw;
			out_ready  <= (stall_draw == 0);
		end else if (take_stall > 0) begin
			take_stall <= take_stall - 1;
			out_ready  <= (take_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		cmd_t c;
		c.action     = ACT_PUSH;
		c.byte_value = b;
		c.last_byte  = last;
		pending_words.push_back(c);
		queued_items++;
	endtask

	// Pop request with noise in the ignored fields
	task automatic queue_pop();
		cmd_t c;
		c.action     = ACT_POP;
		c.byte_value = 8'($urandom_range(0, 255));
		c.last_byte  = 1'($urandom_range(0, 1));
		pending_words.push_back(c);
		queued_items++;
	endtask

	// Frame of random bytes, sometimes with a pop while it is partial
	task automatic queue_frame(input int unsigned len);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				queue_pop();
			queue_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	// Mostly short frames, some full-size and overlong ones, pops in between
	task automatic queue_random(input int unsigned n);
		int unsigned stop_at;
		int unsigned pick;
		stop_at = queued_items + n;
		while (queued_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				queue_pop();
			else if (pick < 42)
				queue_frame(1);
			else if (pick < 47)
				queue_frame(FRAME_BYTES);
			else if (pick < 50)
				queue_frame($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8));
			else if (pick < 56)
				queue_frame($urandom_range(9, FRAME_BYTES - 1));
			else
				queue_frame($urandom_range(2, 8));
		end
	endtask

	// Wait until every word is sent and every owed word is back, then drain
	task automatic settle();
		while (pending_words.size() != 0 || in_valid || pop_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_min_fill(input logic [FILL_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we        <= 1'b0;
		ring_min_fill = v;
	endtask

	initial begin
		ring_held     = 0;
		ring_head     = 0;
		ring_woff     = 0;
		ring_min_fill = MIN_FILL_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty ring, below threshold, pop during a partial frame
		queue_pop();
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b1);
		queue_pop();
		queue_byte(8'h01, 1'b0);
		queue_pop();
		queue_byte(8'h7F, 1'b1);
		queue_pop();
		queue_pop();
		settle();

		// zero threshold acts like one; drain to empty
		set_min_fill(4'd0);
		queue_pop();
		queue_pop();
		queue_pop();
		queue_byte(8'hAA, 1'b1);
		queue_pop();
		settle();

		// full ring: pop gives none, next frame flushes the ring
		set_min_fill(4'd15);
		for (int i = 0; i < SLOTS; i++)
			queue_frame($urandom_range(1, 3));
		queue_pop();
		queue_frame(2);
		for (int i = 0; i < 14; i++)
			queue_frame(1);
		queue_pop();
		queue_pop();
		queue_random(25);
		settle();

		// overlong and exact-size frames
		set_min_fill(4'd1);
		queue_frame(FRAME_BYTES + 4);
		queue_frame(FRAME_BYTES);
		queue_pop();
		queue_pop();
		queue_random(25);
		settle();

		repeat (4) begin
			set_min_fill(4'($urandom_range(0, 15)));
			queue_random(25);
			settle();
		end

		if (mismatch_count == 0 && pop_words_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/vfjq_pkg.sv
rtl/core/vfjq_ram.sv
rtl/core/vfjq_front.sv
rtl/core/vfjq_back.sv
rtl/core/voice_frame_jitter_queue.sv
verif/tb_top.sv
